/* hdl/buzvol_pkg.sv */
package buzvol_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_DIV,
        ST_SAT,
        ST_MUL,
        ST_OUT
    } state_t;

    // Configuration register indexes
    localparam logic CFG_TIMER_CLOCK   = 1'b0;
    localparam logic CFG_POLL_INTERVAL = 1'b1;

    // Input kinds carried on s_tuser
    localparam logic ACT_TONE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Reset values of the configuration registers
    localparam logic [23:0] TIMER_CLOCK_RST   = 24'd164000;
    localparam logic [15:0] POLL_INTERVAL_RST = 16'd80;

    // Width of the clock count and number of restoring divider steps
    localparam int DIV_STEPS = 24;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

endpackage

/* hdl/buzzer_tone_with_volume_top.sv */
// Buzzer tone controller with knob volume. Each transfer on the s_ side is
// either a tone request (s_tuser low: frequency and duration) or a one
// millisecond tick (s_tuser high: knob sample), and each gives exactly one
// result transfer on the m_ side showing the PWM period, the PWM compare
// value, the tone flag and the filtered volume. The block takes one item at
// a time. A tick runs the shift-add multiplier only when the knob poll
// falls due while a tone sounds and does not end on that tick; a tone
// request with a non-zero frequency runs the divider and then the multiplier,
// and one with frequency zero goes straight to the output register. s_tready
// rises again in the same cycle as m_tvalid shows the loaded result. The
// PWM period comes from the bit-serial restoring divider (one quotient bit
// per cycle, 24 steps for clock / frequency, then a clamp step) and the
// compare value from the shift-add multiplier (one volume bit per cycle).
// The output register frees the m_ side: a new item is taken while a result
// still waits, and the block stalls only if a second result is ready before
// the first is taken. Configuration writes must be made while idle.
module buzzer_tone_with_volume_top #(
    parameter int KNOB_BITS = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [23:0]                      cfg_wdata,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] tone_frequency, [31:16] tone_duration_ms, [43:32] knob_sample
    input  logic [buzvol_pkg::IN_TDATA_W-1:0] s_tdata,
    // [0] action
    input  logic                             s_tuser,
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] period_value, [30:16] compare_value, [31] tone_active,
    // [43:32] volume_level
    output logic [buzvol_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import buzvol_pkg::*;

    localparam int STEPS_MAX = (KNOB_BITS > DIV_STEPS) ? KNOB_BITS : DIV_STEPS;
    localparam int CNT_W     = $clog2(STEPS_MAX);

    // Input fields
    logic [15:0]          tone_freq;
    logic [15:0]          tone_dur;
    logic [11:0]          knob_raw;
    logic [KNOB_BITS-1:0] sample_k;

    assign tone_freq = s_tdata[15:0];
    assign tone_dur  = s_tdata[31:16];
    assign knob_raw  = s_tdata[43:32];
    // Keep only the low KNOB_BITS of the sample (zero-extend if wider)
    assign sample_k  = KNOB_BITS'(knob_raw);

    // State
    state_t                state_reg, state_next;
    logic [23:0]           clk_hz_reg, clk_hz_next;
    logic [15:0]           poll_int_reg, poll_int_next;
    logic [31:0]           now_reg, now_next;
    logic [31:0]           off_reg, off_next;
    logic [31:0]           due_reg, due_next;
    logic                  sounding_reg, sounding_next;
    logic [15:0]           period_reg, period_next;
    logic [14:0]           compare_reg, compare_next;
    logic [KNOB_BITS-1:0]  volume_reg, volume_next;

    // Divider: dividend shifts out at the top while quotient bits shift in
    logic [23:0]           dvd_reg, dvd_next;
    logic [15:0]           rem_reg, rem_next;
    logic [15:0]           dvs_reg, dvs_next;

    // Multiplier: right-shifting accumulator keeps only the high half
    logic [14:0]           mcand_reg, mcand_next;
    logic [KNOB_BITS-1:0]  mplier_reg, mplier_next;
    logic [15:0]           acc_reg, acc_next;

    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // Datapath helpers
    logic [16:0]           rem_shift;
    logic [16:0]           rem_diff;
    logic                  q_bit;
    logic [23:0]           quot_m1;
    logic [15:0]           period_sat;
    logic [15:0]           acc_sum;
    logic [31:0]           off_delta;
    logic [31:0]           due_delta;
    logic                  off_hit;
    logic                  poll_hit;
    logic [KNOB_BITS+1:0]  filt_sum;
    logic [KNOB_BITS-1:0]  vol_filt;
    logic                  out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Restoring divide step: bring in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, dvd_reg[23]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign q_bit     = (rem_shift >= {1'b0, dvs_reg});

    // Period is quotient minus one, clamped to 16 bits; zero quotient gives 0
    assign quot_m1 = dvd_reg - 24'd1;
    always_comb begin
        if (dvd_reg == 24'd0) begin
            period_sat = 16'd0;
        end else if (quot_m1[23:16] != 8'd0) begin
            period_sat = 16'hFFFF;
        end else begin
            period_sat = quot_m1[15:0];
        end
    end

    // Shift-add step: add the multiplicand if the current volume bit is set
    assign acc_sum = acc_reg + (mplier_reg[0] ? {1'b0, mcand_reg} : 16'd0);

    // Signed-wrap time checks against the already advanced millisecond count
    assign off_delta = now_reg - off_reg;
    assign due_delta = now_reg - due_reg;
    assign off_hit   = sounding_reg && !off_delta[31];
    assign poll_hit  = !due_delta[31];

    // Knob low-pass on the sample held since acceptance: (3 * volume + sample) / 4
    assign filt_sum = {2'b00, volume_reg} + {1'b0, volume_reg, 1'b0}
                      + {2'b00, mplier_reg};
    assign vol_filt = filt_sum[KNOB_BITS+1:2];

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        clk_hz_next    = clk_hz_reg;
        poll_int_next  = poll_int_reg;
        now_next       = now_reg;
        off_next       = off_reg;
        due_next       = due_reg;
        sounding_next  = sounding_reg;
        period_next    = period_reg;
        compare_next   = compare_reg;
        volume_next    = volume_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // Drop the result once the downstream side takes it
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        // Configuration writes land whenever enabled
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TIMER_CLOCK:   clk_hz_next   = cfg_wdata;
                CFG_POLL_INTERVAL: poll_int_next = cfg_wdata[15:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == ACT_TONE) begin
                        // Arm the off time and, for a non-zero frequency, start the period division
                        off_next      = now_reg + {16'd0, tone_dur};
                        sounding_next = 1'b1;
                        if (tone_freq == 16'd0) begin
                            period_next  = 16'd0;
                            compare_next = 15'd0;
                            state_next   = ST_OUT;
                        end else begin
                            dvd_next   = clk_hz_reg;
                            rem_next   = 16'd0;
                            dvs_next   = tone_freq;
                            cnt_next   = '0;
                            state_next = ST_DIV;
                        end
                    end else begin
                        // Advance time; checks follow on the new count
                        now_next    = now_reg + 32'd1;
                        mplier_next = sample_k;
                        state_next  = ST_TICK;
                    end
                end
            end

            ST_TICK: begin
                // Sample held in mplier_reg since acceptance
                if (off_hit) begin
                    sounding_next = 1'b0;
                    period_next   = 16'd0;
                    compare_next  = 15'd0;
                end
                state_next = ST_OUT;
                if (poll_hit) begin
                    volume_next = vol_filt;
                    due_next    = now_reg + {16'd0, poll_int_reg};
                    if (sounding_reg && !off_hit) begin
                        mcand_next  = period_reg[15:1];
                        mplier_next = vol_filt;
                        acc_next    = 16'd0;
                        cnt_next    = '0;
                        state_next  = ST_MUL;
                    end
                end
            end

            ST_DIV: begin
                rem_next = q_bit ? rem_diff[15:0] : rem_shift[15:0];
                dvd_next = {dvd_reg[22:0], q_bit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_SAT;
                end
            end

            ST_SAT: begin
                period_next = period_sat;
                mcand_next  = period_sat[15:1];
                mplier_next = volume_reg;
                acc_next    = 16'd0;
                cnt_next    = '0;
                state_next  = ST_MUL;
            end

            ST_MUL: begin
                acc_next    = {1'b0, acc_sum[15:1]};
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(KNOB_BITS - 1)) begin
                    compare_next = acc_sum[15:1];
                    state_next   = ST_OUT;
                end
            end

            ST_OUT: begin
                // Hold until the output register is free, then load the result
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'd0, 12'(volume_reg), sounding_reg,
                                      compare_reg, period_reg};
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            clk_hz_reg    <= TIMER_CLOCK_RST;
            poll_int_reg  <= POLL_INTERVAL_RST;
            now_reg       <= 32'd0;
            off_reg       <= 32'd0;
            due_reg       <= 32'd0;
            sounding_reg  <= 1'b0;
            period_reg    <= 16'd0;
            compare_reg   <= 15'd0;
            volume_reg    <= KNOB_BITS'(1) << (KNOB_BITS - 1);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clk_hz_reg    <= clk_hz_next;
            poll_int_reg  <= poll_int_next;
            now_reg       <= now_next;
            off_reg       <= off_next;
            due_reg       <= due_next;
            sounding_reg  <= sounding_next;
            period_reg    <= period_next;
            compare_reg   <= compare_next;
            volume_reg    <= volume_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath shift registers and result payload
    always_ff @(posedge aclk) begin
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

endmodule

/* hdl/buzvol_checker.sv */
module buzvol_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // Result register comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One item at a time: no acceptance in the cycle after a transfer in
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    // Compare never exceeds half the period, so a zero period has zero compare
    a_compare_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[30:16] <= m_tdata[15:1])
        else $error("compare value above half period");

endmodule

bind buzzer_tone_with_volume_top buzvol_checker u_buzvol_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
